>>> rtl/core/tkhs_pkg.sv
package tkhs_pkg;

    // Defaults for the top level parameters
    localparam int K_MAX_DEF      = 8;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed field widths
    localparam int IDX_W  = 16;
    localparam int SUM_W  = 32;
    localparam int CFG_W  = 4;
    localparam int KIND_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SMALL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIG   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

    // Operation broadcast to every cell of the sorted chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] key_index;
    } t_cell_ctl;

endpackage

>>> rtl/core/top_k_heap_splitter_core.sv
// Streaming top-k selector.
// Input channel (i_valid / o_ready) takes one value per transaction, with
// i_last_item marking the end of a stream. Output channel (o_valid / i_ready)
// delivers small evictions, then on the last item the kept big entries in
// ascending order, then one total transaction with o_last_result set.
// The user must write k_big through i_cfg_we / i_cfg_data only while
// the block is idle; the block itself does not enforce this. An item
// that causes no result needs only its insert, so such items can follow
// back to back. Each eviction, each flushed entry and the total need one
// load of the single output register; the sorted chain of K_MAX+1 cells
// inserts or shifts by one slot per cycle while that register is free.
// An item's first result is loaded in the S_EVICT or S_FLUSH state after
// its acceptance. A stalled receiver holds the output register; the chain
// then waits and o_ready stays low until the last pending result is in
// the output register. Results already registered never block the
// acceptance of an item that needs no output. Reset empties the chain,
// clears the arrival counter, sum and k_big, and drops any pending result.
module top_k_heap_splitter_core #(
    parameter int K_MAX      = tkhs_pkg::K_MAX_DEF,
    parameter int VALUE_BITS = tkhs_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tkhs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic                         i_last_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tkhs_pkg::KIND_W-1:0]  o_kind,
    output logic [tkhs_pkg::IDX_W-1:0]   o_item_index,
    output logic [VALUE_BITS-1:0]        o_item_value,
    output logic [tkhs_pkg::SUM_W-1:0]   o_total,
    output logic                         o_last_result
);
    import tkhs_pkg::*;

    localparam int NCELL = K_MAX + 1;
    localparam int CW    = $clog2(K_MAX + 2);
    localparam int CMPW  = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVICT,
        S_FLUSH
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [IDX_W-1:0]      r_arrival, n_arrival;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [CFG_W-1:0]      r_k, n_k;
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    logic [KIND_W-1:0]     r_out_kind, n_out_kind;
    logic [IDX_W-1:0]      r_out_index, n_out_index;
    logic [VALUE_BITS-1:0] r_out_value, n_out_value;
    logic [SUM_W-1:0]      r_out_total, n_out_total;
    logic                  r_out_last, n_out_last;

    t_cell_ctl             w_ctl;
    logic                  w_valid [NCELL];
    logic [VALUE_BITS-1:0] w_value [NCELL];
    logic [IDX_W-1:0]      w_index [NCELL];
    logic                  w_gt    [NCELL];

    logic [CMPW-1:0]       w_k_ext, w_keff, w_cnt_inc, w_cnt_dec;
    logic [SUM_W-1:0]      w_addend, w_sum_sat;
    logic [SUM_W:0]        w_sum_ext;
    logic                  w_out_free;

    // Sorted chain, smallest entry in cell 0
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic                  lv, lg, rv;
        logic [VALUE_BITS-1:0] lval, rval;
        logic [IDX_W-1:0]      lidx, ridx;

        if (g == 0) begin : g_first
            assign lv   = 1'b0;
            assign lg   = 1'b0;
            assign lval = '0;
            assign lidx = '0;
        end else begin : g_left
            assign lv   = w_valid[g-1];
            assign lg   = w_gt[g-1];
            assign lval = w_value[g-1];
            assign lidx = w_index[g-1];
        end

        if (g == NCELL - 1) begin : g_end
            assign rv   = 1'b0;
            assign rval = '0;
            assign ridx = '0;
        end else begin : g_right
            assign rv   = w_valid[g+1];
            assign rval = w_value[g+1];
            assign ridx = w_index[g+1];
        end

        tkhs_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_key_value   (i_value),
            .i_left_valid  (lv),
            .i_left_gt     (lg),
            .i_left_value  (lval),
            .i_left_index  (lidx),
            .i_right_valid (rv),
            .i_right_value (rval),
            .i_right_index (ridx),
            .o_valid       (w_valid[g]),
            .o_value       (w_value[g]),
            .o_index       (w_index[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Effective k, clamped to K_MAX, one less than the chain size
    assign w_k_ext   = CMPW'(r_k);
    assign w_keff    = (w_k_ext > CMPW'(K_MAX)) ? CMPW'(K_MAX) : w_k_ext;
    assign w_cnt_inc = CMPW'(r_count) + 1'b1;
    assign w_cnt_dec = CMPW'(r_count) - 1'b1;

    // Saturating sum: evicted value, or one per big entry during the flush
    assign w_addend  = (r_state == S_EVICT) ? SUM_W'(w_value[0]) : SUM_W'(1);
    assign w_sum_ext = {1'b0, r_sum} + {1'b0, w_addend};
    assign w_sum_sat = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];

    assign w_out_free = !r_out_valid || i_ready;

    // Next state, chain command and output register load
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_arrival     = r_arrival;
        n_sum         = r_sum;
        n_k           = r_k;
        n_last        = r_last;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_kind    = r_out_kind;
        n_out_index   = r_out_index;
        n_out_value   = r_out_value;
        n_out_total   = r_out_total;
        n_out_last    = r_out_last;
        w_ctl.op        = OP_HOLD;
        w_ctl.key_index = r_arrival + 1'b1;

        if (i_cfg_we) begin
            n_k = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_ctl.op  = OP_INSERT;
                    n_arrival = w_ctl.key_index;
                    n_count   = r_count + 1'b1;
                    n_last    = i_last_item;
                    if (w_cnt_inc > w_keff) begin
                        n_state = S_EVICT;
                    end else if (i_last_item) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_EVICT: begin
                if (w_out_free) begin
                    w_ctl.op    = OP_SHIFT;
                    n_count     = r_count - 1'b1;
                    n_sum       = w_sum_sat;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SMALL;
                    n_out_index = w_index[0];
                    n_out_value = w_value[0];
                    n_out_total = '0;
                    n_out_last  = 1'b0;
                    if (w_cnt_dec <= w_keff) begin
                        n_state = r_last ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_count != '0) begin
                        w_ctl.op    = OP_SHIFT;
                        n_count     = r_count - 1'b1;
                        n_sum       = w_sum_sat;
                        n_out_kind  = KIND_BIG;
                        n_out_index = w_index[0];
                        n_out_value = w_value[0];
                        n_out_total = '0;
                        n_out_last  = 1'b0;
                    end else begin
                        // Total closes the stream and clears it
                        w_ctl.op    = OP_CLEAR;
                        n_out_kind  = KIND_TOTAL;
                        n_out_index = '0;
                        n_out_value = '0;
                        n_out_total = r_sum;
                        n_out_last  = 1'b1;
                        n_count     = '0;
                        n_arrival   = '0;
                        n_sum       = '0;
                        n_last      = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_arrival   <= '0;
            r_sum       <= '0;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_arrival   <= n_arrival;
            r_sum       <= n_sum;
            r_k         <= n_k;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_out_kind  <= n_out_kind;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_item_index  = r_out_index;
    assign o_item_value  = r_out_value;
    assign o_total       = r_out_total;
    assign o_last_result = r_out_last;

endmodule

>>> rtl/core/tkhs_cell.sv
module tkhs_cell #(
    parameter int VALUE_BITS = tkhs_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tkhs_pkg::t_cell_ctl         i_ctl,
    input  logic [VALUE_BITS-1:0]       i_key_value,
    input  logic                        i_left_valid,
    input  logic                        i_left_gt,
    input  logic [VALUE_BITS-1:0]       i_left_value,
    input  logic [tkhs_pkg::IDX_W-1:0]  i_left_index,
    input  logic                        i_right_valid,
    input  logic [VALUE_BITS-1:0]       i_right_value,
    input  logic [tkhs_pkg::IDX_W-1:0]  i_right_index,
    output logic                        o_valid,
    output logic [VALUE_BITS-1:0]       o_value,
    output logic [tkhs_pkg::IDX_W-1:0]  o_index,
    output logic                        o_gt
);
    import tkhs_pkg::*;

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [IDX_W-1:0]      r_index;
    logic                  n_valid;
    logic [VALUE_BITS-1:0] n_value;
    logic [IDX_W-1:0]      n_index;

    // Entry sorts after the key; an empty slot counts as larger than anything
    assign o_gt = !r_valid || (r_value > i_key_value) ||
                  ((r_value == i_key_value) && (r_index > i_ctl.key_index));

    // Insert: larger entries move one slot right, the key lands at the boundary
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_index = r_index;
        unique case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                if (o_gt) begin
                    if (i_left_gt) begin
                        n_valid = i_left_valid;
                        n_value = i_left_value;
                        n_index = i_left_index;
                    end else begin
                        n_valid = 1'b1;
                        n_value = i_key_value;
                        n_index = i_ctl.key_index;
                    end
                end
            end
            OP_SHIFT: begin
                n_valid = i_right_valid;
                n_value = i_right_value;
                n_index = i_right_index;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_index <= n_index;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_index = r_index;

endmodule

>>> rtl/core/tkhs_chk.sv
module tkhs_chk #(
    parameter int VALUE_BITS = tkhs_pkg::VALUE_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [tkhs_pkg::CFG_W-1:0]   i_cfg_data,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [VALUE_BITS-1:0]        i_value,
    input logic                         i_last_item,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [tkhs_pkg::KIND_W-1:0]  o_kind,
    input logic [tkhs_pkg::IDX_W-1:0]   o_item_index,
    input logic [VALUE_BITS-1:0]        o_item_value,
    input logic [tkhs_pkg::SUM_W-1:0]   o_total,
    input logic                         o_last_result
);
    import tkhs_pkg::*;

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_item_index)
            && $stable(o_item_value) && $stable(o_total) && $stable(o_last_result))
        else $error("result changed while stalled");

    // The total carries no item and closes the stream
    a_total_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_TOTAL) |->
            o_last_result && (o_item_index == '0) && (o_item_value == '0))
        else $error("malformed total");

    // Small and big results carry no total and never end the stream
    a_item_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_TOTAL) |-> !o_last_result && (o_total == '0))
        else $error("malformed item result");

endmodule

bind top_k_heap_splitter_core tkhs_chk #(
    .VALUE_BITS (VALUE_BITS)
) u_tkhs_chk (.*);
